### hdl/lcs_pkg.sv
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared constants, item types and controller/datapath command structs for
// the LCS row score engine.
// ----------------------------------------------------------------------------
package lcs_pkg;

   // Capacities of the symbol stores
   localparam int MAX_FIRST  = 32;
   localparam int MAX_SECOND = 64;

   // Derived widths
   localparam int SYM_W        = 8;
   localparam int FIRST_IDX_W  = $clog2(MAX_FIRST);
   localparam int FIRST_CNT_W  = $clog2(MAX_FIRST + 1);
   localparam int SECOND_IDX_W = $clog2(MAX_SECOND);
   localparam int SECOND_CNT_W = $clog2(MAX_SECOND + 1);
   localparam int LCS_W        = SECOND_CNT_W;
   localparam int SCORE_DEPTH  = MAX_FIRST + 1;

   // Fixed field and register widths
   localparam int SCORE_W      = 8;
   localparam int ROW_INDEX_W  = 6;
   localparam int FIRST_LEN_W  = 6;
   localparam int SECOND_LEN_W = 7;
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 32;

   // Request codes
   typedef enum logic [1:0] {
      REQ_LOAD_FIRST  = 2'd0,
      REQ_LOAD_SECOND = 2'd1,
      REQ_START       = 2'd2
   } req_code_type;

   // Register indexes (byte address / 4)
   typedef enum logic [1:0] {
      REG_FIRST_LENGTH  = 2'd0,
      REG_SECOND_LENGTH = 2'd1,
      REG_DIRECTION     = 2'd2
   } reg_index_type;

   // Input item
   typedef struct packed {
      logic [1:0]       req_type;
      logic [SYM_W-1:0] symbol;
   } req_item_type;

   // Result item
   typedef struct packed {
      logic [ROW_INDEX_W-1:0] row_index;
      logic [SCORE_W-1:0]     score;
      logic                   last;
   } rsp_item_type;

   // Clamped pass settings
   typedef struct packed {
      logic [FIRST_CNT_W-1:0]  n1;
      logic [SECOND_CNT_W-1:0] n2;
      logic                    backward;
   } pass_cfg_type;

   // Controller to datapath
   typedef struct packed {
      logic load_first;
      logic load_second;
      logic pass_init;
      logic row_start;
      logic cell_rd;
      logic cell_wr;
      logic row_end;
      logic out_rd;
      logic out_load;
      logic pass_done;
   } lcs_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic cell_last;
      logic row_last;
      logic out_last;
      logic out_free;
   } lcs_status_type;

endpackage

### hdl/lcs_ctrl.sv
// ----------------------------------------------------------------------------
// lcs_ctrl
// Sequencer for the LCS row score engine: takes load and start items, walks
// rows and cells of the score table, then drains the stored scores.
// ----------------------------------------------------------------------------
module lcs_ctrl
   import lcs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  logic [1:0]     req_type,
   input  lcs_status_type status,
   output lcs_cmd_type    cmd
);

   typedef enum logic [6:0] {
      S_IDLE     = 7'b000_0001,
      S_ROW      = 7'b000_0010,
      S_CELL_RD  = 7'b000_0100,
      S_CELL_WR  = 7'b000_1000,
      S_ROW_END  = 7'b001_0000,
      S_OUT_RD   = 7'b010_0000,
      S_OUT_LOAD = 7'b100_0000
   } ctrl_state_type;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_type)
                  REQ_LOAD_FIRST:  cmd.load_first  = 1'b1;
                  REQ_LOAD_SECOND: cmd.load_second = 1'b1;
                  REQ_START: begin
                     cmd.pass_init = 1'b1;
                     state_in      = S_ROW;
                  end
                  default: ; // unknown request, dropped
               endcase
            end
         end
         S_ROW: begin
            cmd.row_start = 1'b1;
            state_in      = S_CELL_RD;
         end
         S_CELL_RD: begin
            cmd.cell_rd = 1'b1;
            state_in    = S_CELL_WR;
         end
         S_CELL_WR: begin
            cmd.cell_wr = 1'b1;
            state_in    = status.cell_last ? S_ROW_END : S_CELL_RD;
         end
         S_ROW_END: begin
            cmd.row_end = 1'b1;
            state_in    = status.row_last ? S_OUT_RD : S_ROW;
         end
         S_OUT_RD: begin
            cmd.out_rd = 1'b1;
            state_in   = S_OUT_LOAD;
         end
         S_OUT_LOAD: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               if (status.out_last) begin
                  cmd.pass_done = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  state_in = S_OUT_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Every cell update follows its read cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.cell_wr |-> $past(cmd.cell_rd))
      else $error("cell update without preceding read");

   // A row closes only right after its last cell
   assert property (@(posedge clock) disable iff (reset)
      cmd.row_end |-> $past(cmd.cell_wr && status.cell_last))
      else $error("row end without last cell");

   // Input reopens right after the final result is loaded
   assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && status.out_last) |=> !req_stall)
      else $error("input not reopened after pass");

endmodule

### hdl/lcs_dp.sv
// ----------------------------------------------------------------------------
// lcs_dp
// Datapath for the LCS row score engine: symbol stores, one row buffer,
// score store with valid bits, row/cell/output counters and output register.
// ----------------------------------------------------------------------------
module lcs_dp
   import lcs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  lcs_cmd_type    cmd,
   input  pass_cfg_type   cfg,
   input  req_item_type   req_data,
   output lcs_status_type status,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output rsp_item_type   rsp_data
);

   // Storage
   logic [SYM_W-1:0]   first_mem_ff  [MAX_FIRST];
   logic [SYM_W-1:0]   second_mem_ff [MAX_SECOND];
   logic [LCS_W-1:0]   row_mem_ff    [MAX_SECOND];
   logic [SCORE_W-1:0] score_mem_ff  [SCORE_DEPTH];
   logic [SCORE_DEPTH-1:0] score_vld_ff;

   // Counters and pointers
   logic [FIRST_CNT_W-1:0]  first_fill_ff;
   logic [SECOND_CNT_W-1:0] second_fill_ff;
   logic [FIRST_CNT_W-1:0]  row_ff;
   logic [SECOND_IDX_W-1:0] cell_ff;
   logic [FIRST_CNT_W-1:0]  out_ff;
   logic                    first_row_ff;

   // Cell datapath registers
   logic [SYM_W-1:0]   a_sym_ff;
   logic [SYM_W-1:0]   b_sym_ff;
   logic [LCS_W-1:0]   prev_rd_ff;
   logic [LCS_W-1:0]   left_ff;
   logic [LCS_W-1:0]   diag_ff;
   logic [SCORE_W-1:0] q_rd_ff;
   logic               q_vld_ff;

   // Output register
   logic         rsp_valid_ff;
   rsp_item_type rsp_data_ff;

   // Combinational helpers
   logic [FIRST_CNT_W-1:0]  first_pos;
   logic [SECOND_CNT_W-1:0] second_pos;
   logic [FIRST_CNT_W-1:0]  out_pos;
   logic [FIRST_CNT_W-1:0]  score_ra;
   logic                    score_re;
   logic [FIRST_CNT_W-1:0]  score_wa;
   logic [SCORE_W-1:0]      score_wd;
   logic                    score_we;
   logic [LCS_W-1:0]        prev_val;
   logic [LCS_W-1:0]        cell_val;
   logic [SCORE_W-1:0]      q_value;
   logic [SCORE_W:0]        back_sum;
   logic                    load_first_ok;
   logic                    load_second_ok;

   // Positions: forward walks up, backward walks down from the end
   assign first_pos  = cfg.backward ? (cfg.n1 - FIRST_CNT_W'(1) - row_ff) : row_ff;
   assign second_pos = cfg.backward ? (cfg.n2 - SECOND_CNT_W'(1) - {1'b0, cell_ff})
                                    : {1'b0, cell_ff};
   assign out_pos    = cfg.backward ? (cfg.n1 - out_ff) : out_ff;

   assign load_first_ok  = cmd.load_first  && (int'(first_fill_ff)  < MAX_FIRST);
   assign load_second_ok = cmd.load_second && (int'(second_fill_ff) < MAX_SECOND);

   // Status to controller
   assign status.cell_last = (({1'b0, cell_ff} + SECOND_CNT_W'(1)) == cfg.n2);
   assign status.row_last  = ((row_ff + FIRST_CNT_W'(1)) == cfg.n1);
   assign status.out_last  = (out_ff == cfg.n1);
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   // Load pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         first_fill_ff  <= '0;
         second_fill_ff <= '0;
      end else if (cmd.pass_done) begin
         first_fill_ff  <= '0;
         second_fill_ff <= '0;
      end else begin
         if (load_first_ok)  first_fill_ff  <= first_fill_ff + FIRST_CNT_W'(1);
         if (load_second_ok) second_fill_ff <= second_fill_ff + SECOND_CNT_W'(1);
      end
   end

   // Symbol stores, read registered
   always_ff @(posedge clock) begin
      if (load_first_ok) first_mem_ff[first_fill_ff[FIRST_IDX_W-1:0]] <= req_data.symbol;
      if (cmd.row_start) a_sym_ff <= first_mem_ff[first_pos[FIRST_IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (load_second_ok) begin
         second_mem_ff[second_fill_ff[SECOND_IDX_W-1:0]] <= req_data.symbol;
      end
      if (cmd.cell_rd) b_sym_ff <= second_mem_ff[second_pos[SECOND_IDX_W-1:0]];
   end

   // Row/cell/output counters
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         cell_ff      <= '0;
         out_ff       <= '0;
         first_row_ff <= 1'b0;
      end else begin
         if (cmd.pass_init) begin
            row_ff       <= '0;
            out_ff       <= '0;
            first_row_ff <= 1'b1;
         end
         if (cmd.row_end) begin
            row_ff       <= row_ff + FIRST_CNT_W'(1);
            first_row_ff <= 1'b0;
         end
         if (cmd.row_start) cell_ff <= '0;
         if (cmd.cell_wr)   cell_ff <= cell_ff + SECOND_IDX_W'(1);
         if (cmd.out_load)  out_ff  <= out_ff + FIRST_CNT_W'(1);
      end
   end

   // Cell update: match takes diagonal + 1, else the larger neighbor
   assign prev_val = first_row_ff ? '0 : prev_rd_ff;
   assign cell_val = (a_sym_ff == b_sym_ff) ? (diag_ff + LCS_W'(1))
                   : ((left_ff > prev_val) ? left_ff : prev_val);

   // Row buffer holds the previous row; overwritten in place
   always_ff @(posedge clock) begin
      if (cmd.cell_rd) prev_rd_ff <= row_mem_ff[cell_ff];
      if (cmd.cell_wr) row_mem_ff[cell_ff] <= cell_val;
   end

   always_ff @(posedge clock) begin
      if (cmd.row_start) begin
         left_ff <= '0;
         diag_ff <= '0;
      end else if (cmd.cell_wr) begin
         left_ff <= cell_val;
         diag_ff <= prev_val;
      end
   end

   // Score store access
   assign q_value  = q_vld_ff ? q_rd_ff : '0;
   assign back_sum = {1'b0, q_value} + (SCORE_W + 1)'(left_ff);
   assign score_re = cmd.row_start || cmd.out_rd;
   assign score_ra = cmd.out_rd ? out_pos : first_pos;

   always_comb begin
      score_we = 1'b0;
      score_wa = first_pos;
      score_wd = '0;
      if (cmd.pass_init && !cfg.backward) begin
         score_we = 1'b1;
         score_wa = '0;
      end else if (cmd.row_end) begin
         score_we = 1'b1;
         if (cfg.backward) begin
            score_wa = first_pos;
            score_wd = back_sum[SCORE_W] ? '1 : back_sum[SCORE_W-1:0];
         end else begin
            score_wa = row_ff + FIRST_CNT_W'(1);
            score_wd = SCORE_W'(left_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (score_we) score_mem_ff[score_wa] <= score_wd;
      if (score_re) q_rd_ff <= score_mem_ff[score_ra];
   end

   // Valid bits: an unwritten score reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         score_vld_ff <= '0;
         q_vld_ff     <= 1'b0;
      end else begin
         if (score_we) score_vld_ff[score_wa] <= 1'b1;
         if (score_re) q_vld_ff <= score_vld_ff[score_ra];
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff.row_index <= ROW_INDEX_W'(out_pos);
         rsp_data_ff.score     <= q_value;
         rsp_data_ff.last      <= status.out_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A waiting result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwritten while stalled");

   // Load pointer never passes capacity
   assert property (@(posedge clock) disable iff (reset)
      int'(first_fill_ff) <= MAX_FIRST && int'(second_fill_ff) <= MAX_SECOND)
      else $error("load pointer beyond capacity");

endmodule

### hdl/lcs_row_score_engine_top.sv
// ----------------------------------------------------------------------------
// lcs_row_score_engine_top
// LCS row score engine: loads two byte strings; a start item runs the two-row
// LCS length table and emits the prefix score row, or adds suffix scores to it.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | req_item_type (req_type, symbol)
//   rsp     | out       | rsp_valid/rsp_stall | rsp_item_type (row_index, score, last)
//   csr     | in        | APB psel/penable    | first_length, second_length, direction
//
// Load items are taken one per cycle while no pass runs. A start item walks
// each row cell by cell, a read state then a write state per cell on the
// single row buffer, then loads each score into the output register; result
// side stalls lengthen the pass. The input is stalled for the whole pass,
// from start until the last result is loaded into the output register. Reset
// is synchronous; it sets both lengths to one and clears the direction, load pointers and score valid bits.
// ----------------------------------------------------------------------------
module lcs_row_score_engine_top
   import lcs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Input channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_item_type          req_data,
   // Result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_item_type          rsp_data,
   // Configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [FIRST_LEN_W-1:0]  first_length_ff;
   logic [SECOND_LEN_W-1:0] second_length_ff;
   logic                    direction_ff;
   logic                    csr_wr;
   logic [1:0]              csr_idx;
   pass_cfg_type            cfg;
   lcs_cmd_type             cmd;
   lcs_status_type          status;

   // Register write decode
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         first_length_ff  <= FIRST_LEN_W'(1);
         second_length_ff <= SECOND_LEN_W'(1);
         direction_ff     <= 1'b0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_FIRST_LENGTH:  first_length_ff  <= csr_pwdata[FIRST_LEN_W-1:0];
            REG_SECOND_LENGTH: second_length_ff <= csr_pwdata[SECOND_LEN_W-1:0];
            REG_DIRECTION:     direction_ff     <= csr_pwdata[0];
            default: ; // no register here
         endcase
      end
   end

   // Register read
   always_comb begin
      unique case (csr_idx)
         REG_FIRST_LENGTH:  csr_prdata = CSR_DATA_W'(first_length_ff);
         REG_SECOND_LENGTH: csr_prdata = CSR_DATA_W'(second_length_ff);
         REG_DIRECTION:     csr_prdata = CSR_DATA_W'(direction_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // Clamp lengths: zero counts as one, above capacity counts as capacity
   always_comb begin
      if (first_length_ff == '0) begin
         cfg.n1 = FIRST_CNT_W'(1);
      end else if (int'(first_length_ff) > MAX_FIRST) begin
         cfg.n1 = FIRST_CNT_W'(MAX_FIRST);
      end else begin
         cfg.n1 = FIRST_CNT_W'(first_length_ff);
      end
      if (second_length_ff == '0) begin
         cfg.n2 = SECOND_CNT_W'(1);
      end else if (int'(second_length_ff) > MAX_SECOND) begin
         cfg.n2 = SECOND_CNT_W'(MAX_SECOND);
      end else begin
         cfg.n2 = SECOND_CNT_W'(second_length_ff);
      end
      cfg.backward = direction_ff;
   end

   lcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_type  (req_data.req_type),
      .status    (status),
      .cmd       (cmd)
   );

   lcs_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cfg       (cfg),
      .req_data  (req_data),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### test/lcs_row_score_engine_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_row_score_engine_top_tb
// Self-checking bench for the LCS row score engine. Symbols are loaded
// into both strings and start items run passes. A behavioral copy of the
// two-row LCS table predicts every score item, and each score item is checked
// field by field. A short table of directed items comes first. It is
// followed by a forced saturating run of backward passes, then random
// load/start sequences under several register settings. The sender idles
// in bursts and the score side stalls in changing patterns.
// ----------------------------------------------------------------------------
module lcs_row_score_engine_top_tb;
   import lcs_pkg::*;

   localparam int          CLOCK_HALF_NS  = 6;
   localparam int          RESET_CYCLES   = 6;
   localparam int          SETTLE_CYCLES  = 16;
   localparam int          RANDOM_ITEMS   = 330;
   localparam int          LARGE_PHASES   = 6;
   localparam int          NUM_DIRECTED   = 27;
   localparam logic [1:0]  REQ_UNKNOWN    = 2'd3;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;
   typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_RUNS} stall_mode_type;

   // One row of directed stimulus: an item, or a register write
   typedef struct packed {
      row_kind_type       kind;
      logic [1:0]         code;
      logic [7:0]         value;
      logic               typed;
      logic [SCORE_W-1:0] typed_score;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_item_type          req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_item_type          rsp_data;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   lcs_row_score_engine_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Directed items; typed scores are the last score item of that pass
   stim_row_type directed_rows [NUM_DIRECTED] = '{
      '{ROW_ITEM, REQ_LOAD_FIRST,    8'h00, 1'b0, 8'd0},
      '{ROW_ITEM, REQ_LOAD_SECOND,   8'h00, 1'b0, 8'd0},
      '{ROW_ITEM, REQ_START,         8'h00, 1'b1, 8'd1},
      '{ROW_ITEM, REQ_UNKNOWN,       8'hFF, 1'b0, 8'd0},
      '{ROW_CSR,  REG_DIRECTION,     8'd1,  1'b0, 8'd0},
      '{ROW_ITEM, REQ_START,         8'hFF, 1'b1, 8'd1},
      // zero lengths count as one symbol
      '{ROW_CSR,  REG_FIRST_LENGTH,  8'd0,  1'b0, 8'd0},
      '{ROW_CSR,  REG_SECOND_LENGTH, 8'd0,  1'b0, 8'd0},
      '{ROW_ITEM, REQ_START,         8'h00, 1'b1, 8'd2},
      '{ROW_CSR,  REG_FIRST_LENGTH,  8'd2,  1'b0, 8'd0},
      '{ROW_CSR,  REG_SECOND_LENGTH, 8'd3,  1'b0, 8'd0},
      '{ROW_CSR,  REG_DIRECTION,     8'd0,  1'b0, 8'd0},
      '{ROW_ITEM, REQ_LOAD_FIRST,    8'hFF, 1'b0, 8'd0},
      '{ROW_ITEM, REQ_LOAD_SECOND,   8'h00, 1'b0, 8'd0},
      '{ROW_ITEM, REQ_LOAD_FIRST,    8'h00, 1'b0, 8'd0},
      '{ROW_ITEM, REQ_LOAD_SECOND,   8'hFF, 1'b0, 8'd0},
      '{ROW_ITEM, REQ_LOAD_SECOND,   8'h00, 1'b0, 8'd0},
      '{ROW_ITEM, REQ_START,         8'h00, 1'b1, 8'd2},
      // backward over the symbols still stored after the rewind
      '{ROW_CSR,  REG_DIRECTION,     8'd1,  1'b0, 8'd0},
      '{ROW_ITEM, REQ_START,         8'h00, 1'b0, 8'd0},
      '{ROW_CSR,  REG_FIRST_LENGTH,  8'd1,  1'b0, 8'd0},
      '{ROW_CSR,  REG_SECOND_LENGTH, 8'd1,  1'b0, 8'd0},
      '{ROW_CSR,  REG_DIRECTION,     8'd0,  1'b0, 8'd0},
      '{ROW_ITEM, REQ_LOAD_FIRST,    8'h5A, 1'b0, 8'd0},
      '{ROW_ITEM, REQ_LOAD_SECOND,   8'hA5, 1'b0, 8'd0},
      '{ROW_ITEM, REQ_START,         8'h00, 1'b1, 8'd0},
      '{ROW_ITEM, REQ_UNKNOWN,       8'h00, 1'b0, 8'd0}
   };

   // Predictor state
   logic [SYM_W-1:0]        first_sym  [MAX_FIRST];
   logic [SYM_W-1:0]        second_sym [MAX_SECOND];
   logic [SCORE_W-1:0]      score_mem  [SCORE_DEPTH];
   int                      first_fill;
   int                      second_fill;
   int                      first_written;
   int                      second_written;
   logic [FIRST_LEN_W-1:0]  first_len_reg;
   logic [SECOND_LEN_W-1:0] second_len_reg;
   logic                    backward_reg;

   rsp_item_type   pending_scores [$];
   int             mismatch_count = 0;
   int             useful_items   = 0;
   int             burst_left     = 0;
   logic           sender_gaps    = 1'b1;
   stall_mode_type stall_mode     = STALL_NONE;
   int             stall_span     = 0;
   int             stall_run      = 0;
   logic           stall_hold     = 1'b0;

   // Clock
   initial begin
      clock = 1'b0;
      forever #(CLOCK_HALF_NS) clock = ~clock;
   end

   // Run limit
   initial begin
      #12_000_000;
      $display("** lcs_row_score_engine_top: FAILED **");
      $finish;
   end

   // Effective pass lengths after clamping
   function automatic int eff_first();
      if (first_len_reg == 0) return 1;
      if (first_len_reg > MAX_FIRST) return MAX_FIRST;
      return int'(first_len_reg);
   endfunction

   function automatic int eff_second();
      if (second_len_reg == 0) return 1;
      if (second_len_reg > MAX_SECOND) return MAX_SECOND;
      return int'(second_len_reg);
   endfunction

   // Applies one accepted item to the predictor and queues its score items
   task automatic lcs_score_model(input req_item_type item);
      int           n1;
      int           n2;
      int           sum;
      int           idx;
      int           prev_row [MAX_SECOND+1];
      int           cur_row  [MAX_SECOND+1];
      rsp_item_type res;
      case (item.req_type)
         REQ_LOAD_FIRST: begin
            if (first_fill < MAX_FIRST) begin
               first_sym[first_fill] = item.symbol;
               first_fill++;
               if (first_fill > first_written) first_written = first_fill;
               useful_items++;
            end
         end
         REQ_LOAD_SECOND: begin
            if (second_fill < MAX_SECOND) begin
               second_sym[second_fill] = item.symbol;
               second_fill++;
               if (second_fill > second_written) second_written = second_fill;
               useful_items++;
            end
         end
         REQ_START: begin
            useful_items++;
            n1 = eff_first();
            n2 = eff_second();
            foreach (prev_row[j]) begin
               prev_row[j] = 0;
               cur_row[j]  = 0;
            end
            if (!backward_reg) begin
               // prefix scores overwrite the stored row
               score_mem[0] = '0;
               for (int i = 0; i < n1; i++) begin
                  for (int j = 0; j < n2; j++) begin
                     if (first_sym[i] == second_sym[j]) cur_row[j+1] = prev_row[j] + 1;
                     else cur_row[j+1] = (cur_row[j] > prev_row[j+1]) ? cur_row[j]
                                                                        : prev_row[j+1];
                  end
                  score_mem[i+1] = SCORE_W'(cur_row[n2]);
                  prev_row = cur_row;
               end
            end else begin
               // suffix scores accumulate, saturating at the top
               for (int i = n1 - 1; i >= 0; i--) begin
                  for (int j = n2 - 1; j >= 0; j--) begin
                     if (first_sym[i] == second_sym[j]) cur_row[j] = prev_row[j+1] + 1;
                     else cur_row[j] = (cur_row[j+1] > prev_row[j]) ? cur_row[j+1]
                                                                    : prev_row[j];
                  end
                  sum = int'(score_mem[i]) + cur_row[0];
                  score_mem[i] = (sum > 255) ? 8'd255 : SCORE_W'(sum);
                  prev_row = cur_row;
               end
            end
            first_fill  = 0;
            second_fill = 0;
            for (int k = 0; k <= n1; k++) begin
               idx           = backward_reg ? n1 - k : k;
               res.row_index = ROW_INDEX_W'(idx);
               res.score     = score_mem[idx];
               res.last      = (k == n1);
               pending_scores.push_back(res);
            end
         end
         default: ;
      endcase
   endtask

   // Sends one item with burst/gap idling; a typed score replaces the
   // predicted score of the last item of that pass
   task automatic send_item(input req_item_type item, input logic typed,
                            input logic [SCORE_W-1:0] typed_score);
      rsp_item_type tail;
      int           last_pos;
      if (burst_left == 0) begin
         if (sender_gaps) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      lcs_score_model(item);
      if (typed) begin
         last_pos       = pending_scores.size() - 1;
         tail           = pending_scores[last_pos];
         tail.score     = typed_score;
         pending_scores[last_pos] = tail;
      end
   endtask

   // Drops valid and waits until every score item is in, plus settle time
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_scores.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write: setup phase, access phase until ready, then idle
   task automatic csr_write(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_FIRST_LENGTH:  first_len_reg  = value[FIRST_LEN_W-1:0];
         REG_SECOND_LENGTH: second_len_reg = value[SECOND_LEN_W-1:0];
         REG_DIRECTION:     backward_reg   = value[0];
         default: ;
      endcase
   endtask

   // Loads both strings in random interleave, with optional noise, then starts
   task automatic run_sequence(input int first_count, input int second_count,
                               input logic [7:0] base, input int span,
                               input logic noise, input logic full_range);
      req_item_type item;
      int           left1;
      int           left2;
      logic         pick_first;
      left1 = first_count;
      left2 = second_count;
      while (left1 > 0 || left2 > 0) begin
         if (noise && $urandom_range(0, 9) == 0) begin
            item.req_type = REQ_UNKNOWN;
            item.symbol   = 8'($urandom);
            send_item(item, 1'b0, '0);
         end
         pick_first  = (left1 > 0) && (left2 == 0 || $urandom_range(0, 1) == 1);
         item.symbol = full_range ? 8'($urandom) : base + 8'($urandom_range(0, span));
         if (pick_first) begin
            item.req_type = REQ_LOAD_FIRST;
            left1--;
         end else begin
            item.req_type = REQ_LOAD_SECOND;
            left2--;
         end
         send_item(item, 1'b0, '0);
      end
      item.req_type = REQ_START;
      item.symbol   = 8'($urandom);
      send_item(item, 1'b0, '0);
   endtask

   // Score side stall pattern: none, random, or runs, switching over time
   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 2));
         stall_span = $urandom_range(16, 160);
      end else begin
         stall_span--;
      end
      case (stall_mode)
         STALL_NONE:   rsp_stall <= 1'b0;
         STALL_RANDOM: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: begin
            if (stall_run == 0) begin
               stall_hold = !stall_hold;
               stall_run  = $urandom_range(1, 8);
            end
            stall_run--;
            rsp_stall <= stall_hold;
         end
      endcase
   end

   // Score item checker
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_scores.size() == 0) begin
            $display("%0t: unexpected score item: row_index %0d score %0d last %0b",
                     $time, rsp_data.row_index, rsp_data.score, rsp_data.last);
            mismatch_count++;
         end else begin
            want = pending_scores.pop_front();
            if (rsp_data.row_index !== want.row_index) begin
               $display("%0t: row_index mismatch: expected %0d, actual %0d",
                        $time, want.row_index, rsp_data.row_index);
               mismatch_count++;
            end
            if (rsp_data.score !== want.score) begin
               $display("%0t: score mismatch at row %0d: expected %0d, actual %0d",
                        $time, want.row_index, want.score, rsp_data.score);
               mismatch_count++;
            end
            if (rsp_data.last !== want.last) begin
               $display("%0t: last mismatch at row %0d: expected %0b, actual %0b",
                        $time, want.row_index, want.last, rsp_data.last);
               mismatch_count++;
            end
         end
      end
   end

   // Stimulus
   initial begin
      req_item_type item;
      int           large_left;
      int           first_len;
      int           second_len;
      int           n1;
      int           n2;
      int           k1;
      int           k2;

      // known inputs and reset values of the predictor
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      rsp_stall   <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      foreach (first_sym[i]) first_sym[i] = '0;
      foreach (second_sym[i]) second_sym[i] = '0;
      foreach (score_mem[i]) score_mem[i] = '0;
      first_fill     = 0;
      second_fill    = 0;
      first_written  = 0;
      second_written = 0;
      first_len_reg  = FIRST_LEN_W'(1);
      second_len_reg = SECOND_LEN_W'(1);
      backward_reg   = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_CSR) begin
            wait_idle();
            csr_write(reg_index_type'(directed_rows[r].code),
                      CSR_DATA_W'(directed_rows[r].value));
         end else begin
            item.req_type = directed_rows[r].code;
            item.symbol   = directed_rows[r].value;
            send_item(item, directed_rows[r].typed, directed_rows[r].typed_score);
         end
      end

      // full-size backward passes over equal symbols until the scores
      // saturate; lengths above capacity and loads past capacity
      useful_items = 0;
      wait_idle();
      csr_write(REG_FIRST_LENGTH, CSR_DATA_W'(63));
      csr_write(REG_SECOND_LENGTH, CSR_DATA_W'(127));
      csr_write(REG_DIRECTION, CSR_DATA_W'(1));
      run_sequence(MAX_FIRST + 2, MAX_SECOND + 2, 8'h3C, 0, 1'b0, 1'b0);
      item.req_type = REQ_START;
      item.symbol   = 8'h00;
      repeat (8) send_item(item, 1'b0, '0);

      // random phases, mostly small sizes
      large_left = LARGE_PHASES;
      while (useful_items < RANDOM_ITEMS) begin
         wait_idle();
         sender_gaps = ($urandom_range(0, 3) != 0);
         if (large_left > 0 && $urandom_range(0, 7) == 0) begin
            large_left--;
            first_len  = $urandom_range(24, 63);
            second_len = $urandom_range(40, 127);
         end else begin
            first_len  = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 8);
            second_len = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 16);
         end
         csr_write(REG_FIRST_LENGTH, CSR_DATA_W'(first_len));
         csr_write(REG_SECOND_LENGTH, CSR_DATA_W'(second_len));
         csr_write(REG_DIRECTION, CSR_DATA_W'($urandom_range(0, 1)));
         repeat ($urandom_range(1, 3)) begin
            n1 = eff_first();
            n2 = eff_second();
            // never read a symbol slot that was never written
            k1 = (first_written < n1) ? n1 : $urandom_range(0, n1);
            k2 = (second_written < n2) ? n2 : $urandom_range(0, n2);
            if ($urandom_range(0, 15) == 0) k1 = MAX_FIRST + $urandom_range(1, 2);
            if ($urandom_range(0, 15) == 0) k2 = MAX_SECOND + $urandom_range(1, 2);
            run_sequence(k1, k2, 8'($urandom), $urandom_range(0, 3), 1'b1,
                         $urandom_range(0, 3) == 0);
            item.req_type = REQ_START;
            item.symbol   = 8'($urandom);
            repeat ($urandom_range(0, 1)) send_item(item, 1'b0, '0);
         end
      end

      wait_idle();
      if (mismatch_count == 0) begin
         $display("** lcs_row_score_engine_top: PASSED **");
      end else begin
         $display("** lcs_row_score_engine_top: FAILED **");
      end
      $finish;
   end

endmodule

### lcs_row_score_engine_top.f
hdl/lcs_pkg.sv
hdl/lcs_ctrl.sv
hdl/lcs_dp.sv
hdl/lcs_row_score_engine_top.sv
test/lcs_row_score_engine_top_tb.sv
